### src/hddc_pkg.sv
// Package with the types, offsets and defaults shared by the HDMI DDC register block.
`timescale 1ns / 1ps

package hddc_pkg;

  localparam int REG_WORDS_DEF  = 512;
  localparam int EDID_BYTES_DEF = 256;

  localparam logic [11:0] OFF_HOTPLUG   = 12'h00C;
  localparam logic [11:0] OFF_CTRL      = 12'h500;
  localparam logic [11:0] OFF_SLAVE     = 12'h504;
  localparam logic [11:0] OFF_INT       = 12'h50C;
  localparam logic [11:0] OFF_FIFO_CTRL = 12'h510;
  localparam logic [11:0] OFF_FIFO_DATA = 12'h518;
  localparam logic [11:0] OFF_CMD       = 12'h520;
  localparam logic [11:0] OFF_LIMIT     = 12'h544;

  localparam logic [31:0] CMD_EDID_READ = 32'd6;

  localparam int BIT_RESET = 0;
  localparam int BIT_START = 30;
  localparam int BIT_CLEAR = 31;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_LOAD  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RSEL_ZERO = 2'd0,
    RSEL_ONE  = 2'd1,
    RSEL_WORD = 2'd2,
    RSEL_EDID = 2'd3
  } rsel_t;

endpackage

### src/hdmi_ddc_edid_register_block.sv
// Top level of the HDMI DDC register block with its register memory and EDID store.
//
//   channel  ports                                     handshake
//   input    in_op in_offset in_write_data             start, taken when busy is low
//            in_edid_index in_edid_byte
//   result   out_read_data                             out_valid, one-cycle strobe
//
// Each result appears on the cycle after its item is taken,
// since both memories have a registered read port. A new item can follow every cycle.
// After reset busy stays high while the register memory is cleared,
// one word a cycle. The receiver cannot stall, so nothing else holds items off.
`timescale 1ns / 1ps

module hdmi_ddc_edid_register_block
  import hddc_pkg::*;
#(
  parameter int REG_WORDS  = REG_WORDS_DEF,
  parameter int EDID_BYTES = EDID_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [11:0] in_offset,
  input  logic [31:0] in_write_data,
  input  logic [7:0]  in_edid_index,
  input  logic [7:0]  in_edid_byte,
  output logic        out_valid,
  output logic [31:0] out_read_data
);

  localparam int AW  = $clog2(REG_WORDS);
  localparam int EAW = $clog2(EDID_BYTES);

  logic [31:0] reg_mem [REG_WORDS];
  logic [7:0]  edid_mem [EDID_BYTES];

  logic          clearing_r;
  logic [AW-1:0] clr_cnt_r;
  logic [7:0]    ptr_r, ptr_nxt;
  logic [31:0]   cmd_r, slave_r, int_r;
  logic          out_valid_r;
  rsel_t         rsel_r, rsel_nxt;
  logic [31:0]   rd_word_r;
  logic [7:0]    rd_edid_r;

  op_t           op;
  logic          acc;
  logic          in_range;
  logic          wr_item;
  logic          ld_item;
  logic [AW-1:0] word_idx;
  logic [31:0]   wval;
  logic          ptr_load;
  logic          fifo_rd;
  logic [8:0]    ptr_ext;
  logic [8:0]    ptr_wrap;
  logic [EAW-1:0] edid_raddr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;

  assign op       = op_t'(in_op);
  assign busy     = clearing_r;
  assign acc      = start && !clearing_r;
  assign in_range = in_offset < OFF_LIMIT;
  assign wr_item  = acc && op == OP_WRITE && in_range;
  assign ld_item  = acc && op == OP_LOAD && ({1'b0, in_edid_index} < 9'(EDID_BYTES));
  assign fifo_rd  = acc && op == OP_READ && in_offset == OFF_FIFO_DATA;
  assign word_idx = AW'(in_offset[11:2]);

  assign ptr_ext    = {1'b0, ptr_r};
  assign ptr_wrap   = (ptr_ext >= 9'(EDID_BYTES)) ? ptr_ext - 9'(EDID_BYTES) : ptr_ext;
  assign edid_raddr = ptr_wrap[EAW-1:0];

  always_comb begin
    wval     = in_write_data;
    ptr_load = 1'b0;
    if (in_offset == OFF_CTRL) begin
      wval[BIT_RESET] = 1'b0;
      if (wval[BIT_START]) begin
        wval[BIT_START] = 1'b0;
        if (cmd_r == CMD_EDID_READ && slave_r[31:24] == 8'd0) begin
          ptr_load = 1'b1;
        end
      end
    end else if (in_offset == OFF_INT) begin
      wval = (int_r & ~{24'd0, in_write_data[7:0]}) | 32'd1;
    end else if (in_offset == OFF_FIFO_CTRL) begin
      wval[BIT_CLEAR] = 1'b0;
    end
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (fifo_rd) begin
      ptr_nxt = ptr_r + 8'd1;
    end else if (wr_item && ptr_load) begin
      ptr_nxt = slave_r[15:8];
    end
  end

  always_comb begin
    rsel_nxt = RSEL_ZERO;
    if (op == OP_READ && in_range) begin
      if (in_offset == OFF_HOTPLUG) begin
        rsel_nxt = RSEL_ONE;
      end else if (in_offset == OFF_FIFO_DATA) begin
        rsel_nxt = RSEL_EDID;
      end else begin
        rsel_nxt = RSEL_WORD;
      end
    end
  end

  assign mem_we    = clearing_r || wr_item;
  assign mem_waddr = clearing_r ? clr_cnt_r : word_idx;
  assign mem_wdata = clearing_r ? 32'd0 : wval;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      reg_mem[mem_waddr] <= mem_wdata;
    end
    rd_word_r <= reg_mem[word_idx];
  end

  always_ff @(posedge clk) begin
    if (ld_item) begin
      edid_mem[in_edid_index[EAW-1:0]] <= in_edid_byte;
    end
    rd_edid_r <= edid_mem[edid_raddr];
  end

  always_ff @(posedge clk) begin
    rsel_r <= rsel_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      ptr_r       <= 8'd0;
      cmd_r       <= 32'd0;
      slave_r     <= 32'd0;
      int_r       <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(REG_WORDS - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      ptr_r       <= ptr_nxt;
      out_valid_r <= acc;
      if (wr_item) begin
        if (in_offset[11:2] == OFF_CMD[11:2]) begin
          cmd_r <= wval;
        end
        if (in_offset[11:2] == OFF_SLAVE[11:2]) begin
          slave_r <= wval;
        end
        if (in_offset[11:2] == OFF_INT[11:2]) begin
          int_r <= wval;
        end
      end
    end
  end

  always_comb begin
    case (rsel_r)
      RSEL_ONE:  out_read_data = 32'd1;
      RSEL_WORD: out_read_data = rd_word_r;
      RSEL_EDID: out_read_data = {24'd0, rd_edid_r};
      default:   out_read_data = 32'd0;
    endcase
  end

  assign out_valid = out_valid_r;

  a_strobe_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (out_valid == $past(start && !busy)))
    else $error("result strobe does not follow the accepted item");

  a_hotplug_reads_one: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && op == OP_READ && in_offset == OFF_HOTPLUG) |=> (out_read_data == 32'd1))
    else $error("hotplug status did not read as one");

  a_non_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && op != OP_READ) |=> (out_valid && out_read_data == 32'd0))
    else $error("write or load item returned nonzero data");

  a_fifo_ptr_advance: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_rd |=> (ptr_r == $past(ptr_r) + 8'd1))
    else $error("EDID pointer did not advance after a FIFO read");

endmodule

### bench/hdmi_ddc_edid_register_block_tb.sv
// Self-checking testbench for the HDMI DDC register block with its EDID store.
`timescale 1ns / 1ps

module hdmi_ddc_edid_register_block_tb;
  import hddc_pkg::*;

  localparam int TARGET_ITEMS = 1150;
  localparam int TAIL_ITEMS = 150;
  localparam int STALL_LIMIT = 2000;
  localparam int PRINT_LIMIT = 40;
  localparam int RW_AW = $clog2(REG_WORDS_DEF);

  typedef struct packed {
    op_t         op;
    logic [11:0] offset;
    logic [31:0] write_data;
    logic [7:0]  edid_index;
    logic [7:0]  edid_byte;
  } access_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_op = '0;
  logic [11:0] in_offset = '0;
  logic [31:0] in_write_data = '0;
  logic [7:0]  in_edid_index = '0;
  logic [7:0]  in_edid_byte = '0;
  logic        out_valid;
  logic [31:0] out_read_data;

  // Index 0 is the planning copy used while stimulus is built; index 1 tracks the block.
  logic [31:0] reg_shadow[2][REG_WORDS_DEF];
  logic [7:0]  edid_shadow[2][EDID_BYTES_DEF];
  logic [7:0]  pointer_shadow[2];
  bit          edid_loaded[EDID_BYTES_DEF];

  access_t     access_queue[$];
  logic [31:0] read_data_due[$];

  int  mismatches = 0;
  int  items_planned = 0;
  int  effective_planned = 0;
  int  items_taken = 0;
  int  results_seen = 0;
  int  reads_taken = 0;
  int  fifo_reads_taken = 0;
  int  writes_taken = 0;
  int  loads_taken = 0;
  int  pointer_loads = 0;
  int  idle_left = 0;
  int  stall_cycles = 0;
  bit  item_taken = 1'b0;

  hdmi_ddc_edid_register_block dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_op        (in_op),
    .in_offset    (in_offset),
    .in_write_data(in_write_data),
    .in_edid_index(in_edid_index),
    .in_edid_byte (in_edid_byte),
    .out_valid    (out_valid),
    .out_read_data(out_read_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("MISMATCH at %0t ns: %s", $realtime, what);
  endtask

  // Applies one access to a copy of the register file and EDID store.
  task automatic predict_access(input bit side, input access_t a, output logic [31:0] rd);
    logic [31:0] v;
    logic [31:0] slave;
    rd = '0;
    case (a.op)
      OP_READ: begin
        if (a.offset >= OFF_LIMIT) rd = '0;
        else if (a.offset == OFF_HOTPLUG) rd = 32'd1;
        else if (a.offset == OFF_FIFO_DATA) begin
          rd = {24'd0, edid_shadow[side][pointer_shadow[side]]};
          pointer_shadow[side] = pointer_shadow[side] + 8'd1;
        end else rd = reg_shadow[side][RW_AW'(a.offset[11:2])];
      end
      OP_WRITE: begin
        if (a.offset < OFF_LIMIT) begin
          v = a.write_data;
          if (a.offset == OFF_CTRL) begin
            v[BIT_RESET] = 1'b0;
            if (v[BIT_START]) begin
              v[BIT_START] = 1'b0;
              slave = reg_shadow[side][RW_AW'(OFF_SLAVE[11:2])];
              if (reg_shadow[side][RW_AW'(OFF_CMD[11:2])] == CMD_EDID_READ &&
                  slave[31:24] == 8'd0)
              begin
                pointer_shadow[side] = slave[15:8];
                if (side) pointer_loads++;
              end
            end
          end else if (a.offset == OFF_INT) begin
            v = (reg_shadow[side][RW_AW'(OFF_INT[11:2])] & ~{24'd0, a.write_data[7:0]}) |
                32'd1;
          end else if (a.offset == OFF_FIFO_CTRL) begin
            v[BIT_CLEAR] = 1'b0;
          end
          reg_shadow[side][RW_AW'(a.offset[11:2])] = v;
        end
      end
      OP_LOAD: begin
        edid_shadow[side][a.edid_index] = a.edid_byte;
        edid_loaded[a.edid_index] = 1'b1;
      end
      default: rd = '0;
    endcase
  endtask

  // Queues one access; a FIFO read of a never-loaded byte gets a load in front of it.
  task automatic plan_access(input op_t op, input logic [11:0] offset, input logic [31:0] wd,
                             input logic [7:0] ei, input logic [7:0] eb);
    access_t a;
    logic [31:0] unused_rd;
    if (op == OP_READ && offset == OFF_FIFO_DATA && !edid_loaded[pointer_shadow[0]])
      plan_access(OP_LOAD, 12'($urandom), $urandom, pointer_shadow[0], 8'($urandom));
    a.op = op;
    a.offset = offset;
    a.write_data = (op == OP_WRITE) ? wd : $urandom;
    a.edid_index = (op == OP_LOAD) ? ei : 8'($urandom);
    a.edid_byte = (op == OP_LOAD) ? eb : 8'($urandom);
    predict_access(1'b0, a, unused_rd);
    access_queue.push_back(a);
    items_planned++;
    if (op != OP_NONE && !(op == OP_WRITE && offset >= OFF_LIMIT)) effective_planned++;
  endtask

  always @(negedge clk) begin
    access_t a;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || item_taken) begin
      if (idle_left > 0) begin
        idle_left = idle_left - 1;
        start <= 1'b0;
      end else if (access_queue.size() == 0) begin
        start <= 1'b0;
      end else if (access_queue.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
        idle_left = $urandom_range(0, 10);
        start <= 1'b0;
      end else begin
        a = access_queue.pop_front();
        start <= 1'b1;
        in_op <= a.op;
        in_offset <= a.offset;
        in_write_data <= a.write_data;
        in_edid_index <= a.edid_index;
        in_edid_byte <= a.edid_byte;
      end
    end
  end

  always @(posedge clk) begin
    access_t a;
    logic [31:0] due;
    logic [31:0] rd;
    bit accepted;
    if (!rst_n) begin
      item_taken <= 1'b0;
    end else begin
      accepted = start && (busy === 1'b0);
      if (out_valid === 1'b1) begin
        results_seen++;
        if (read_data_due.size() == 0) begin
          flag_mismatch($sformatf("result 0x%08h with no item outstanding", out_read_data));
        end else begin
          due = read_data_due.pop_front();
          if (out_read_data !== due)
            flag_mismatch($sformatf("read_data 0x%08h, expected 0x%08h", out_read_data, due));
        end
      end
      if (accepted) begin
        a.op = op_t'(in_op);
        a.offset = in_offset;
        a.write_data = in_write_data;
        a.edid_index = in_edid_index;
        a.edid_byte = in_edid_byte;
        predict_access(1'b1, a, rd);
        read_data_due.push_back(rd);
        items_taken++;
        if (a.op == OP_READ) reads_taken++;
        if (a.op == OP_READ && a.offset == OFF_FIFO_DATA) fifo_reads_taken++;
        if (a.op == OP_WRITE) writes_taken++;
        if (a.op == OP_LOAD) loads_taken++;
      end
      item_taken <= accepted;
      if (accepted || out_valid === 1'b1) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    logic [11:0] special_offsets[10];
    logic [11:0] off;
    logic [7:0]  p;
    int n;
    int kind;
    special_offsets = '{OFF_HOTPLUG, OFF_CTRL, OFF_SLAVE, OFF_INT, OFF_FIFO_CTRL,
                        OFF_FIFO_DATA, OFF_CMD, OFF_LIMIT - 12'd4, OFF_LIMIT, 12'hFFC};
    for (int s = 0; s < 2; s++) begin
      for (int i = 0; i < REG_WORDS_DEF; i++) reg_shadow[s][i] = '0;
      for (int i = 0; i < EDID_BYTES_DEF; i++) edid_shadow[s][i] = '0;
      pointer_shadow[s] = '0;
    end
    for (int i = 0; i < EDID_BYTES_DEF; i++) edid_loaded[i] = 1'b0;

    // Directed part: hotplug, pointer load with wrap, blocked pointer loads,
    // masked control bits, interrupt clearing, out-of-range and unaligned offsets.
    plan_access(OP_READ, OFF_HOTPLUG, 0, 0, 0);
    plan_access(OP_WRITE, OFF_HOTPLUG, 32'hFFFF_FFFF, 0, 0);
    plan_access(OP_READ, OFF_HOTPLUG, 0, 0, 0);
    plan_access(OP_LOAD, 0, 0, 8'd255, 8'hFF);
    plan_access(OP_LOAD, 0, 0, 8'd0, 8'h00);
    plan_access(OP_WRITE, OFF_CMD, CMD_EDID_READ, 0, 0);
    plan_access(OP_WRITE, OFF_SLAVE, 32'h00A5_FF3C, 0, 0);
    plan_access(OP_WRITE, OFF_CTRL, 32'hFFFF_FFFF, 0, 0);
    plan_access(OP_READ, OFF_CTRL, 0, 0, 0);
    plan_access(OP_READ, OFF_FIFO_DATA, 0, 0, 0);
    plan_access(OP_READ, OFF_FIFO_DATA, 0, 0, 0);
    plan_access(OP_WRITE, OFF_SLAVE, 32'h0100_8000, 0, 0);
    plan_access(OP_WRITE, OFF_CTRL, 32'h4000_0000, 0, 0);
    plan_access(OP_WRITE, OFF_CMD, 32'd7, 0, 0);
    plan_access(OP_WRITE, OFF_CTRL, 32'h4000_0001, 0, 0);
    plan_access(OP_READ, OFF_FIFO_DATA, 0, 0, 0);
    plan_access(OP_WRITE, OFF_INT, 32'hFFFF_FFFF, 0, 0);
    plan_access(OP_WRITE, OFF_INT, 32'h0000_0000, 0, 0);
    plan_access(OP_READ, OFF_INT, 0, 0, 0);
    plan_access(OP_WRITE, OFF_FIFO_CTRL, 32'hFFFF_FFFF, 0, 0);
    plan_access(OP_READ, OFF_FIFO_CTRL, 0, 0, 0);
    plan_access(OP_WRITE, OFF_LIMIT, 32'h1234_5678, 0, 0);
    plan_access(OP_READ, OFF_LIMIT, 0, 0, 0);
    plan_access(OP_WRITE, 12'h501, 32'hDEAD_BEEF, 0, 0);
    plan_access(OP_READ, 12'h500, 0, 0, 0);
    plan_access(OP_READ, 12'h519, 0, 0, 0);
    plan_access(OP_NONE, 12'hFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    plan_access(OP_READ, 12'hFFC, 0, 0, 0);

    while (effective_planned < TARGET_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        p = 8'($urandom);
        n = $urandom_range(1, 8);
        if ($urandom_range(0, 1) == 1)
          for (int k = 0; k < n; k++) plan_access(OP_LOAD, 0, 0, p + 8'(k), 8'($urandom));
        plan_access(OP_WRITE, OFF_CMD,
                    ($urandom_range(0, 7) == 0) ? 32'($urandom) : CMD_EDID_READ, 0, 0);
        plan_access(OP_WRITE, OFF_SLAVE,
                    {($urandom_range(0, 5) == 0) ? 8'($urandom_range(1, 255)) : 8'd0,
                     8'($urandom), p, 8'($urandom)}, 0, 0);
        if ($urandom_range(0, 5) == 0) plan_access(OP_WRITE, OFF_INT, $urandom, 0, 0);
        plan_access(OP_WRITE, OFF_CTRL,
                    ($urandom_range(0, 5) == 0) ? ($urandom & ~(32'd1 << BIT_START))
                                                : ($urandom | (32'd1 << BIT_START)), 0, 0);
        for (int k = 0; k < n; k++) plan_access(OP_READ, OFF_FIFO_DATA, 0, 0, 0);
        if ($urandom_range(0, 3) == 0) plan_access(OP_READ, OFF_CTRL, 0, 0, 0);
      end else if (kind == 4) begin
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) plan_access(OP_LOAD, 0, 0, 8'($urandom), 8'($urandom));
      end else if (kind == 5) begin
        plan_access(OP_WRITE, OFF_INT, $urandom, 0, 0);
        plan_access(OP_READ, OFF_INT, 0, 0, 0);
      end else if (kind == 6) begin
        off = special_offsets[$urandom_range(0, 9)];
        if ($urandom_range(0, 3) == 0) off = off + 12'($urandom_range(1, 3));
        plan_access(OP_WRITE, off, ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom, 0, 0);
        plan_access(OP_READ, off, 0, 0, 0);
      end else if (kind == 7) begin
        off = {10'($urandom_range(0, (OFF_LIMIT >> 2) - 1)), 2'b00};
        plan_access(OP_WRITE, off, $urandom, 0, 0);
        plan_access(OP_READ, off, 0, 0, 0);
      end else if (kind == 8) begin
        plan_access(op_t'($urandom_range(0, 3)), 12'($urandom), $urandom,
                    8'($urandom), 8'($urandom));
      end else begin
        plan_access(OP_READ, 12'($urandom), 0, 0, 0);
      end
    end

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    while (items_taken < items_planned || read_data_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (read_data_due.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", read_data_due.size()));

    $display("Ran %0d items: %0d reads (%0d from the EDID FIFO), %0d writes, %0d EDID loads.",
             items_taken, reads_taken, fifo_reads_taken, writes_taken, loads_taken);
    $display("Checked %0d results; the FIFO pointer was loaded %0d times; %0d mismatches.",
             results_seen, pointer_loads, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
